// ===== design/hsv565_pkg.sv =====
// Shared types and constants for the HSV to RGB565 converter.
// No dependencies; imported by every design module of the block.
package hsv565_pkg;

    // Field widths
    localparam int HUE_W = 16;
    localparam int SV_W  = 9;
    localparam int RGB_W = 16;

    // Smallest multiple of 360 that lifts any 16-bit signed hue to >= 0
    localparam logic [16:0] HUE_OFFSET      = 17'd33120;
    // Reciprocal of 360: ceil(2^25 / 360), exact for values below 65888
    localparam logic [16:0] RECIP_360       = 17'd93207;
    localparam int          RECIP_360_SHIFT = 25;
    localparam logic [8:0]  DEG_CIRCLE      = 9'd360;
    localparam logic [8:0]  SECTOR_DEG      = 9'd60;
    // Reciprocal of 60: ceil(2^28 / 60), exact for numerators below 2^22
    localparam logic [22:0] RECIP_60        = 23'd4473925;
    localparam int          RECIP_60_SHIFT  = 28;
    // Q0.8 full scale
    localparam logic [8:0]  SV_FULL         = 9'd256;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } sector_t;

    // Transaction handed from the hue stages to the mixing stages
    typedef struct packed {
        logic        valid;
        sector_t     sector;
        logic [5:0]  hp;
        logic [16:0] c;
        logic [8:0]  v;
    } hsv565_sect_t;

endpackage

// ===== design/hsv565_hue.sv =====
// Hue front end: reduces the hue modulo 360, splits it into sector and
// offset, and forms chroma. Three register stages. Depends on hsv565_pkg.
module hsv565_hue
    import hsv565_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [HUE_W-1:0]   hue,
    input  logic [SV_W-1:0]    saturation,
    input  logic [SV_W-1:0]    brightness,
    output hsv565_sect_t       sect
);

    // Stage A: offset hue, reciprocal multiply, clamp s and v
    logic        a_valid_reg;
    logic [16:0] a_u_reg;
    logic [7:0]  a_q_reg;
    logic [8:0]  a_s_reg;
    logic [8:0]  a_v_reg;

    logic [16:0] a_u_next;
    logic [33:0] a_prod;
    logic [8:0]  a_s_next;
    logic [8:0]  a_v_next;

    always_comb
    begin
        a_u_next = {hue[HUE_W-1], hue} + HUE_OFFSET;
        a_prod   = 34'(a_u_next) * 34'(RECIP_360);
        a_s_next = (saturation > SV_FULL) ? SV_FULL : saturation;
        a_v_next = (brightness > SV_FULL) ? SV_FULL : brightness;
    end

    // Stage B: remainder modulo 360 with one correction step, chroma product
    logic        b_valid_reg;
    logic [8:0]  b_h_reg;
    logic [16:0] b_c_reg;
    logic [8:0]  b_v_reg;

    logic [16:0] b_qx;
    logic [16:0] b_rem;
    logic [16:0] b_rem_fix;
    logic [17:0] b_cprod;

    always_comb
    begin
        b_qx      = 17'(a_q_reg) * 17'(DEG_CIRCLE);
        b_rem     = a_u_reg - b_qx;
        b_rem_fix = (b_rem >= 17'(DEG_CIRCLE)) ? (b_rem - 17'(DEG_CIRCLE)) : b_rem;
        b_cprod   = a_s_reg * a_v_reg;
    end

    // Stage C: sector and offset within the sector
    logic        c_valid_reg;
    sector_t     c_sector_reg;
    logic [5:0]  c_hp_reg;
    logic [16:0] c_c_reg;
    logic [8:0]  c_v_reg;

    sector_t     c_sector_next;
    logic [8:0]  c_base;

    always_comb
    begin
        priority if (b_h_reg >= 9'd300)
        begin
            c_sector_next = SECT_MAGENTA_RED;
            c_base        = 9'd300;
        end
        else if (b_h_reg >= 9'd240)
        begin
            c_sector_next = SECT_BLUE_MAGENTA;
            c_base        = 9'd240;
        end
        else if (b_h_reg >= 9'd180)
        begin
            c_sector_next = SECT_CYAN_BLUE;
            c_base        = 9'd180;
        end
        else if (b_h_reg >= 9'd120)
        begin
            c_sector_next = SECT_GREEN_CYAN;
            c_base        = 9'd120;
        end
        else if (b_h_reg >= SECTOR_DEG)
        begin
            c_sector_next = SECT_YELLOW_GREEN;
            c_base        = SECTOR_DEG;
        end
        else
        begin
            c_sector_next = SECT_RED_YELLOW;
            c_base        = 9'd0;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        a_u_reg      <= a_u_next;
        a_q_reg      <= a_prod[RECIP_360_SHIFT+7:RECIP_360_SHIFT];
        a_s_reg      <= a_s_next;
        a_v_reg      <= a_v_next;
        b_h_reg      <= b_rem_fix[8:0];
        b_c_reg      <= b_cprod[16:0];
        b_v_reg      <= a_v_reg;
        c_sector_reg <= c_sector_next;
        c_hp_reg     <= 6'(b_h_reg - c_base);
        c_c_reg      <= b_c_reg;
        c_v_reg      <= b_v_reg;
    end

    assign sect.valid  = c_valid_reg;
    assign sect.sector = c_sector_reg;
    assign sect.hp     = c_hp_reg;
    assign sect.c      = c_c_reg;
    assign sect.v      = c_v_reg;

endmodule

// ===== design/hsv565_mix.sv =====
// Channel back end: secondary term, offset m, 8-bit scaling and RGB565
// packing. Four register stages, the last one drives the outputs.
// Depends on hsv565_pkg.
module hsv565_mix
    import hsv565_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  hsv565_sect_t       sect,
    output logic               done,
    output logic [RGB_W-1:0]   rgb565
);

    // Stage D: numerator of the secondary term and m = v*256 - c
    logic        d_valid_reg;
    sector_t     d_sector_reg;
    logic [22:0] d_num_reg;
    logic [16:0] d_c_reg;
    logic [16:0] d_m_reg;

    logic [5:0]  d_t;
    logic [22:0] d_num_next;

    always_comb
    begin
        d_t        = sect.sector[0] ? 6'(SECTOR_DEG[5:0] - sect.hp) : sect.hp;
        d_num_next = 23'(sect.c) * 23'(d_t);
    end

    // Stage E: divide by 60 through the reciprocal
    logic        e_valid_reg;
    sector_t     e_sector_reg;
    logic [16:0] e_x_reg;
    logic [16:0] e_c_reg;
    logic [16:0] e_m_reg;

    logic [45:0] e_prod;

    always_comb
    begin
        e_prod = 46'(d_num_reg) * 46'(RECIP_60);
    end

    // Stage F: route c and x to channels and add m
    logic        f_valid_reg;
    logic [16:0] f_r_reg;
    logic [16:0] f_g_reg;
    logic [16:0] f_b_reg;

    logic [16:0] f_r;
    logic [16:0] f_g;
    logic [16:0] f_b;

    always_comb
    begin
        unique case (e_sector_reg)
            SECT_RED_YELLOW:
            begin
                f_r = e_c_reg; f_g = e_x_reg; f_b = '0;
            end
            SECT_YELLOW_GREEN:
            begin
                f_r = e_x_reg; f_g = e_c_reg; f_b = '0;
            end
            SECT_GREEN_CYAN:
            begin
                f_r = '0; f_g = e_c_reg; f_b = e_x_reg;
            end
            SECT_CYAN_BLUE:
            begin
                f_r = '0; f_g = e_x_reg; f_b = e_c_reg;
            end
            SECT_BLUE_MAGENTA:
            begin
                f_r = e_x_reg; f_g = '0; f_b = e_c_reg;
            end
            default:
            begin
                f_r = e_c_reg; f_g = '0; f_b = e_x_reg;
            end
        endcase
    end

    // Stage G: scale by 255/65536 with truncation and pack 5/6/5
    logic             g_valid_reg;
    logic [RGB_W-1:0] g_rgb_reg;

    logic [24:0] g_rs;
    logic [24:0] g_gs;
    logic [24:0] g_bs;
    logic [RGB_W-1:0] g_rgb_next;

    always_comb
    begin
        g_rs       = {f_r_reg, 8'b0} - 25'(f_r_reg);
        g_gs       = {f_g_reg, 8'b0} - 25'(f_g_reg);
        g_bs       = {f_b_reg, 8'b0} - 25'(f_b_reg);
        g_rgb_next = {g_rs[23:19], g_gs[23:18], g_bs[23:19]};
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= sect.valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        d_sector_reg <= sect.sector;
        d_num_reg    <= d_num_next;
        d_c_reg      <= sect.c;
        d_m_reg      <= {sect.v, 8'b0} - sect.c;
        e_sector_reg <= d_sector_reg;
        e_x_reg      <= e_prod[RECIP_60_SHIFT+16:RECIP_60_SHIFT];
        e_c_reg      <= d_c_reg;
        e_m_reg      <= d_m_reg;
        f_r_reg      <= f_r + e_m_reg;
        f_g_reg      <= f_g + e_m_reg;
        f_b_reg      <= f_b + e_m_reg;
        g_rgb_reg    <= g_rgb_next;
    end

    assign done   = g_valid_reg;
    assign rgb565 = g_rgb_reg;

endmodule

// ===== design/hsv_to_rgb565_core.sv =====
// Top level of the HSV to RGB565 converter.
// Depends on hsv565_pkg, hsv565_hue and hsv565_mix.

// Converts one pixel per clock from signed hue (degrees), saturation and
// brightness (Q0.8, values above 256 clamp to 256) to packed RGB565. The
// block never raises busy, so a transaction is taken on every cycle that
// start is high. Each result appears on rgb565 with done high for exactly
// one cycle, once its transaction has passed register stages A to G, in
// order; the receiver cannot stall it and must take it in that cycle.
// Throughput is one pixel per clock, set by a seven-stage pipeline with no
// feedback: three stages reduce the hue (reciprocal multiply by 1/360) and
// form chroma, four form the secondary term (reciprocal multiply by 1/60),
// add the offset, scale to 8 bits and pack.
module hsv_to_rgb565_core
    import hsv565_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [HUE_W-1:0]   hue,
    input  logic [SV_W-1:0]    saturation,
    input  logic [SV_W-1:0]    brightness,
    output logic               done,
    output logic [RGB_W-1:0]   rgb565
);

    hsv565_sect_t sect;

    // Pipeline accepts every cycle
    assign busy = 1'b0;

    hsv565_hue u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .sect       (sect)
    );

    hsv565_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .sect   (sect),
        .done   (done),
        .rgb565 (rgb565)
    );

endmodule

// ===== design/hsv565_checker.sv =====
// Port-level checks for hsv_to_rgb565_core and the bind that attaches them.
// Depends on hsv565_pkg and hsv_to_rgb565_core.
module hsv565_props
    import hsv565_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [SV_W-1:0]    saturation,
    input  logic [SV_W-1:0]    brightness,
    input  logic               done,
    input  logic [RGB_W-1:0]   rgb565
);

    localparam int LATENCY = 7;

    // Never refuse a transaction
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted transaction yields one result after the pipeline delay
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing");

    // No result without a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("spurious result");

    // Zero brightness gives black whatever the hue
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && brightness == 9'd0) |-> ##LATENCY (rgb565 == 16'h0000))
        else $error("black expected");

    // Full brightness with no saturation gives white
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && saturation == 9'd0 && brightness >= SV_FULL)
        |-> ##LATENCY (rgb565 == 16'hFFFF))
        else $error("white expected");

endmodule

bind hsv_to_rgb565_core hsv565_props u_hsv565_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .rgb565     (rgb565)
);

// ===== tb/hsv565_checker.sv =====
// Checker for the HSV to RGB565 converter: predicts each pixel and compares.
// Depends on hsv565_pkg; instantiated by the testbench beside the converter.
`timescale 1ns / 1ps

module hsv565_checker
    import hsv565_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [HUE_W-1:0]   hue,
    input  logic [SV_W-1:0]    saturation,
    input  logic [SV_W-1:0]    brightness,
    input  logic               done,
    input  logic [RGB_W-1:0]   rgb565,
    output int                 mismatches,
    output int                 pending,
    output int                 checked
);

    logic [RGB_W-1:0] expected_pixels[$];

    // Convert one HSV transaction to its packed RGB565 pixel
    function automatic logic [RGB_W-1:0] rgb565_of_hsv(
        input logic [HUE_W-1:0] h_in,
        input logic [SV_W-1:0]  s_in,
        input logic [SV_W-1:0]  v_in
    );
        int          deg;
        int unsigned s_q8;
        int unsigned v_q8;
        int unsigned chroma;
        int unsigned hp;
        int unsigned second;
        int unsigned offset;
        int unsigned r_q16;
        int unsigned g_q16;
        int unsigned b_q16;
        int unsigned r8;
        int unsigned g8;
        int unsigned b8;
        sector_t     sect;
        begin
            // True modulo: negative hues wrap into 0..359
            deg = int'($signed(h_in)) % 360;
            if (deg < 0)
                deg = deg + 360;

            // Clamp Q0.8 inputs to full scale
            s_q8 = (s_in > SV_FULL) ? 256 : s_in;
            v_q8 = (v_in > SV_FULL) ? 256 : v_in;

            chroma = s_q8 * v_q8;
            sect   = sector_t'(deg / 60);
            hp     = deg % 60;
            second = sect[0] ? (chroma * (60 - hp)) / 60 : (chroma * hp) / 60;
            offset = (v_q8 << 8) - chroma;

            case (sect)
                SECT_RED_YELLOW:
                begin
                    r_q16 = chroma; g_q16 = second; b_q16 = 0;
                end
                SECT_YELLOW_GREEN:
                begin
                    r_q16 = second; g_q16 = chroma; b_q16 = 0;
                end
                SECT_GREEN_CYAN:
                begin
                    r_q16 = 0; g_q16 = chroma; b_q16 = second;
                end
                SECT_CYAN_BLUE:
                begin
                    r_q16 = 0; g_q16 = second; b_q16 = chroma;
                end
                SECT_BLUE_MAGENTA:
                begin
                    r_q16 = second; g_q16 = 0; b_q16 = chroma;
                end
                default:
                begin
                    r_q16 = chroma; g_q16 = 0; b_q16 = second;
                end
            endcase

            // Scale to 8 bits with truncation, then keep the top 5/6/5 bits
            r8 = ((r_q16 + offset) * 255) >> 16;
            g8 = ((g_q16 + offset) * 255) >> 16;
            b8 = ((b_q16 + offset) * 255) >> 16;
            return {r8[7:3], g8[7:2], b8[7:3]};
        end
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what);
        begin
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        checked    = 0;
        pending    = 0;
    end

    // Check results first, then queue the prediction for a new transaction
    always @(posedge clk)
    begin
        logic [RGB_W-1:0] want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel 0x%04h", rgb565));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (rgb565 !== want)
                        report_mismatch($sformatf("rgb565 got 0x%04h want 0x%04h",
                                                  rgb565, want));
                end
            end
            if (start && !busy)
                expected_pixels.push_back(rgb565_of_hsv(hue, saturation, brightness));
            pending <= expected_pixels.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the HSV to RGB565 testbench: clock, reset, stimulus and verdict.
// Depends on hsv565_pkg, hsv_to_rgb565_core and hsv565_checker.
`timescale 1ns / 1ps

module testbench
    import hsv565_pkg::*;
;

    localparam int RANDOM_PIXELS = 1130;
    localparam int CALM_TAIL     = 200;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [HUE_W-1:0]   hue;
    logic [SV_W-1:0]    saturation;
    logic [SV_W-1:0]    brightness;
    logic               done;
    logic [RGB_W-1:0]   rgb565;
    int                 mismatches;
    int                 pending;
    int                 checked;
    int                 sent;

    hsv_to_rgb565_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .rgb565     (rgb565)
    );

    hsv565_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .rgb565     (rgb565),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Present one pixel and hold it until the converter takes the transaction
    task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [SV_W-1:0] s,
                              input logic [SV_W-1:0] v);
        begin
            start      <= 1'b1;
            hue        <= h;
            saturation <= s;
            brightness <= v;
            do
                @(posedge clk);
            while (busy);
            sent++;
        end
    endtask

    // Drop start for a short random burst
    task automatic idle_burst();
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Hold off until every expected pixel has come back
    task automatic drain();
        int guard;
        begin
            guard = 0;
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0 && guard < 1000)
            begin
                @(posedge clk);
                guard++;
            end
        end
    endtask

    // Hue: full range, a few turns around zero, or near a sector edge
    function automatic logic [HUE_W-1:0] pick_hue();
        int deg;
        begin
            case ($urandom_range(0, 3))
                0, 1: deg = int'($urandom_range(0, 65535)) - 32768;
                2:    deg = int'($urandom_range(0, 1440)) - 720;
                default:
                    deg = 60 * int'($urandom_range(0, 6)) + int'($urandom_range(0, 2)) - 1
                          + 360 * (int'($urandom_range(0, 180)) - 90);
            endcase
            return deg[HUE_W-1:0];
        end
    endfunction

    // Q0.8 level: mostly in range, some full scale, zero, or over range
    function automatic logic [SV_W-1:0] pick_level();
        begin
            case ($urandom_range(0, 9))
                0:       return SV_FULL;
                1:       return '0;
                2:       return SV_W'($urandom_range(0, 511));
                default: return SV_W'($urandom_range(0, 256));
            endcase
        end
    endfunction

    // Stimulus
    initial
    begin
        sent       = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        hue        <= '0;
        saturation <= '0;
        brightness <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hue extremes, wrap of negative hues, every sector edge
        send_pixel(16'h8000, 9'd256, 9'd256);
        send_pixel(16'h7FFF, 9'd256, 9'd256);
        send_pixel(16'hFFFF, 9'd256, 9'd256);
        send_pixel(16'd0,    9'd256, 9'd256);
        send_pixel(16'd359,  9'd200, 9'd180);
        send_pixel(16'd360,  9'd200, 9'd180);
        send_pixel(16'd59,   9'd256, 9'd256);
        send_pixel(16'd60,   9'd256, 9'd256);
        send_pixel(16'd119,  9'd128, 9'd256);
        send_pixel(16'd120,  9'd128, 9'd256);
        send_pixel(16'd179,  9'd256, 9'd100);
        send_pixel(16'd180,  9'd256, 9'd100);
        send_pixel(16'd239,  9'd77,  9'd233);
        send_pixel(16'd240,  9'd77,  9'd233);
        send_pixel(16'd299,  9'd256, 9'd256);
        send_pixel(16'd300,  9'd256, 9'd256);
        send_pixel(-16'sd60, 9'd256, 9'd256);
        // Grey, black, and clamping of over-range levels
        send_pixel(16'd45,   9'd0,   9'd256);
        send_pixel(16'd45,   9'd0,   9'd131);
        send_pixel(16'd200,  9'd256, 9'd0);
        send_pixel(16'd90,   9'd511, 9'd256);
        send_pixel(16'd210,  9'd256, 9'd511);
        send_pixel(16'd330,  9'd257, 9'd300);
        send_pixel(16'd0,    9'd0,   9'd0);
        drain();

        // Random pixels with idle bursts; a calm tail with start held high
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i == 400 || i == 800)
                drain();
            else if (i < RANDOM_PIXELS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_burst();
            send_pixel(pick_hue(), pick_level(), pick_level());
        end
        drain();
        repeat (12) @(posedge clk);

        $display("Covered %0d pixels (%0d checked): all sectors, hue wrap, level clamping.",
                 sent, checked);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
